/* rtl/core/torus_route_with_mesh_select_core_macros.svh */
// ----------------------------------------------------------------------------
// Torus route assertion macros
// Short forms for the concurrent checks of the torus route core.
// ----------------------------------------------------------------------------
`ifndef TORUS_ROUTE_WITH_MESH_SELECT_CORE_MACROS_SVH
`define TORUS_ROUTE_WITH_MESH_SELECT_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TRMS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TRMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/trms_pkg.sv */
// ----------------------------------------------------------------------------
// Torus route package
// Widths, register indexes, stage layout and helper functions of the core.
// ----------------------------------------------------------------------------
package trms_pkg;

  localparam int MAX_RING     = 64;
  localparam int NODE_ID_BITS = 20;

  localparam int COORD_W    = 6;
  localparam int RING_W     = 7;
  localparam int OFF_W      = 7;
  localparam int HOP_W      = 7;
  localparam int DIM_W      = 2;
  localparam int LINK_W     = 5;
  localparam int MESH_W     = 2;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 7;

  localparam int IN_FIELDS_W  = NODE_ID_BITS + 4 * COORD_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 2 * OFF_W + HOP_W + MESH_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [CFG_ADDR_W-1:0] REG_DIMENSIONS = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_RING_X     = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] REG_RING_Y     = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] REG_NODES      = CFG_ADDR_W'(3);
  localparam logic [CFG_ADDR_W-1:0] REG_LINKS      = CFG_ADDR_W'(4);

  localparam logic [DIM_W-1:0]  RST_DIMENSIONS = DIM_W'(2);
  localparam logic [RING_W-1:0] RST_RING_X     = RING_W'(8);
  localparam logic [RING_W-1:0] RST_RING_Y     = RING_W'(8);
  localparam logic [RING_W-1:0] RST_NODES      = RING_W'(4);
  localparam logic [LINK_W-1:0] RST_LINKS      = LINK_W'(4);

  localparam int NODE_STEP   = 5;
  localparam int NODE_STAGES = (NODE_ID_BITS + NODE_STEP - 1) / NODE_STEP;
  localparam int DIV_W       = RING_W;
  localparam int DIV_STEP    = 4;

  localparam int ST_IN    = 0;
  localparam int ST_LINK0 = NODE_STAGES + 1;
  localparam int ST_LINK1 = NODE_STAGES + 2;
  localparam int ST_RING  = NODE_STAGES + 3;
  localparam int ST_OUT   = NODE_STAGES + 4;
  localparam int NSTG     = NODE_STAGES + 5;

  localparam int OFF_LIM = MAX_RING / 2;
  localparam int HOP_MIN = 2;
  localparam int HOP_MAX = (1 << HOP_W) - 1;

  typedef logic [RING_W-1:0]        rem_t;
  typedef logic [COORD_W-1:0]       coord_t;
  typedef logic signed [OFF_W-1:0]  off_t;

  typedef struct packed {
    logic [NODE_ID_BITS-1:0] node;
    coord_t                  sx;
    coord_t                  sy;
    coord_t                  dx;
    coord_t                  dy;
    coord_t                  adx;
    coord_t                  ady;
    logic                    negx;
    logic                    negy;
    rem_t                    mnx;
    rem_t                    mny;
    rem_t                    rx;
    rem_t                    ry;
    rem_t                    hx;
    rem_t                    hy;
    rem_t                    rn;
    rem_t                    rp;
    off_t                    ox;
    off_t                    oy;
    logic [MESH_W-1:0]       mesh;
    logic [HOP_W-1:0]        hop;
  } pipe_t;

  typedef struct packed {
    logic mesh;
    off_t off;
  } dim_res_t;

  // One restoring remainder step: shift in a dividend bit, subtract if it fits.
  function automatic rem_t rem_step(rem_t rem, logic b, rem_t dv);
    logic [RING_W:0] t;
    t = {rem, b};
    if (t >= {1'b0, dv}) begin
      t = t - {1'b0, dv};
    end
    return t[RING_W-1:0];
  endfunction

  function automatic rem_t ring_clamp(rem_t r);
    rem_t v;
    v = r;
    if (r == '0) begin
      v = RING_W'(1);
    end else if (int'(r) > MAX_RING) begin
      v = RING_W'(MAX_RING);
    end
    return v;
  endfunction

  // Final offset and mesh bit of one ring from the two remainders.
  function automatic dim_res_t ring_final(coord_t s, coord_t ad, logic neg, rem_t m,
                                          rem_t h, rem_t n, logic tie);
    rem_t                   r;
    logic [RING_W:0]        r2;
    logic [RING_W:0]        n1;
    logic signed [RING_W+1:0] off;
    logic signed [RING_W+1:0] e;
    logic [RING_W+1:0]      sum;
    logic                   wrap;
    logic                   same;
    dim_res_t               res;
    r = (m == '0) ? '0 : (neg ? (n - m) : m);
    r2 = {r, 1'b0};
    n1 = {1'b0, n};
    if ((r2 > n1) || ((r2 == n1) && tie)) begin
      off = $signed({2'b00, r}) - $signed({2'b00, n});
    end else begin
      off = $signed({2'b00, r});
    end
    e = $signed({3'b000, s}) + off;
    wrap = e[RING_W+1] || (e >= $signed({2'b00, n}));
    sum = {2'b00, h} + {2'b00, ad, 1'b0};
    same = sum < {2'b00, n};
    res.mesh = wrap ? 1'b1 : (same ? tie : 1'b0);
    res.off = off[OFF_W-1:0];
    return res;
  endfunction

endpackage

/* rtl/core/torus_route_with_mesh_select_core.sv */
// ----------------------------------------------------------------------------
// Torus route with mesh select core
// Minimal dimension-order route for a 1D or 2D torus. The core takes one word
// per cycle while the output does not stall and returns one word per input, in
// order. The pipeline holds the input register, the pipelined remainder unit
// that reduces the node number by the nodes per switch (five bits per stage),
// followed by the two-stage reduction by the parallel link count, one stage
// for the ring offsets and mesh bits and one for the hop count. Ring remainders
// run alongside the node reduction. A stall on the output holds the whole
// pipeline. Configuration must be written only while no word is in flight;
// the core itself does not enforce this.
// ----------------------------------------------------------------------------
module torus_route_with_mesh_select_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [trms_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [trms_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // source_node[19:0], src_x[25:20], src_y[31:26], dst_x[37:32], dst_y[43:38]
  input  logic [trms_pkg::IN_DATA_W-1:0]       in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // offset_x[6:0], offset_y[13:7], hop_count[20:14], mesh_select[22:21]
  output logic [trms_pkg::OUT_DATA_W-1:0]      out_tdata
);
  import trms_pkg::*;

  logic [DIM_W-1:0]  dims_r;
  rem_t              ring_x_r;
  rem_t              ring_y_r;
  rem_t              nodes_r;
  logic [LINK_W-1:0] links_r;

  rem_t nx;
  rem_t ny;
  rem_t nps;
  rem_t lpd;
  logic two_d;
  logic adv;

  logic  [NSTG-1:0] vld_r;
  pipe_t            stg_r   [NSTG];
  pipe_t            stg_nxt [NSTG];

  coord_t   in_sx;
  coord_t   in_sy;
  coord_t   in_dx;
  coord_t   in_dy;
  dim_res_t res_x;
  dim_res_t res_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r   <= RST_DIMENSIONS;
      ring_x_r <= RST_RING_X;
      ring_y_r <= RST_RING_Y;
      nodes_r  <= RST_NODES;
      links_r  <= RST_LINKS;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_DIMENSIONS: dims_r   <= cfg_wdata[DIM_W-1:0];
        REG_RING_X:     ring_x_r <= cfg_wdata[RING_W-1:0];
        REG_RING_Y:     ring_y_r <= cfg_wdata[RING_W-1:0];
        REG_NODES:      nodes_r  <= cfg_wdata[RING_W-1:0];
        REG_LINKS:      links_r  <= cfg_wdata[LINK_W-1:0];
        default: ;
      endcase
    end
  end

  assign nx    = ring_clamp(ring_x_r);
  assign ny    = ring_clamp(ring_y_r);
  assign nps   = (nodes_r == '0) ? RING_W'(1) : nodes_r;
  assign lpd   = (links_r == '0) ? RING_W'(1) : {{(RING_W-LINK_W){1'b0}}, links_r};
  assign two_d = dims_r[1];

  assign adv       = !vld_r[NSTG-1] || out_tready;
  assign in_tready = adv;

  assign in_sx = in_tdata[NODE_ID_BITS +: COORD_W];
  assign in_sy = in_tdata[NODE_ID_BITS + COORD_W +: COORD_W];
  assign in_dx = in_tdata[NODE_ID_BITS + 2 * COORD_W +: COORD_W];
  assign in_dy = in_tdata[NODE_ID_BITS + 3 * COORD_W +: COORD_W];

  assign res_x = ring_final(stg_r[ST_RING-1].sx, stg_r[ST_RING-1].adx,
                            stg_r[ST_RING-1].negx, stg_r[ST_RING-1].rx,
                            stg_r[ST_RING-1].hx, nx, stg_r[ST_RING-1].rp[0]);
  assign res_y = ring_final(stg_r[ST_RING-1].sy, stg_r[ST_RING-1].ady,
                            stg_r[ST_RING-1].negy, stg_r[ST_RING-1].ry,
                            stg_r[ST_RING-1].hy, ny, stg_r[ST_RING-1].rp[1]);

  always_comb begin
    int               idx;
    logic [OFF_W:0]   ax;
    logic [OFF_W:0]   ay;
    logic [OFF_W+1:0] hsum;
    rem_t             adx_w;
    rem_t             ady_w;
    pipe_t            p;

    p        = '0;
    p.node   = in_tdata[NODE_ID_BITS-1:0];
    p.sx     = in_sx;
    p.sy     = in_sy;
    p.dx     = in_dx;
    p.dy     = in_dy;
    p.negx   = in_dx < in_sx;
    p.negy   = in_dy < in_sy;
    p.adx    = p.negx ? (in_sx - in_dx) : (in_dx - in_sx);
    p.ady    = p.negy ? (in_sy - in_dy) : (in_dy - in_sy);
    p.mnx    = {(p.negx ? in_dx : in_sx), 1'b0};
    p.mny    = {(p.negy ? in_dy : in_sy), 1'b0};
    stg_nxt[ST_IN] = p;

    for (int k = 1; k < NSTG; k++) begin
      p = stg_r[k-1];
      if (k <= NODE_STAGES) begin
        for (int j = 0; j < NODE_STEP; j++) begin
          idx = NODE_ID_BITS - 1 - ((k - 1) * NODE_STEP + j);
          if (idx >= 0) begin
            p.rn = rem_step(p.rn, p.node[idx], nps);
          end
        end
      end
      if (k <= 2) begin
        adx_w = RING_W'(p.adx);
        ady_w = RING_W'(p.ady);
        for (int j = 0; j < DIV_STEP; j++) begin
          idx = DIV_W - 1 - ((k - 1) * DIV_STEP + j);
          if (idx >= 0) begin
            p.rx = rem_step(p.rx, adx_w[idx], nx);
            p.ry = rem_step(p.ry, ady_w[idx], ny);
            p.hx = rem_step(p.hx, p.mnx[idx], nx);
            p.hy = rem_step(p.hy, p.mny[idx], ny);
          end
        end
      end
      if (k == ST_LINK0 || k == ST_LINK1) begin
        for (int j = 0; j < DIV_STEP; j++) begin
          idx = DIV_W - 1 - ((k - ST_LINK0) * DIV_STEP + j);
          if (idx >= 0) begin
            p.rp = rem_step(p.rp, p.rn[idx], lpd);
          end
        end
      end
      if (k == ST_RING) begin
        p.ox   = res_x.off;
        p.oy   = two_d ? res_y.off : '0;
        p.mesh = {two_d & res_y.mesh, res_x.mesh};
      end
      if (k == ST_OUT) begin
        ax   = p.ox[OFF_W-1] ? -{p.ox[OFF_W-1], p.ox} : {1'b0, p.ox};
        ay   = p.oy[OFF_W-1] ? -{p.oy[OFF_W-1], p.oy} : {1'b0, p.oy};
        hsum = (OFF_W+2)'(HOP_MIN) + {1'b0, ax} + {1'b0, ay};
        p.hop = (hsum > (OFF_W+2)'(HOP_MAX)) ? HOP_W'(HOP_MAX) : hsum[HOP_W-1:0];
      end
      stg_nxt[k] = p;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NSTG; k++) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  assign out_tvalid = vld_r[NSTG-1];
  assign out_tdata  = {{(OUT_DATA_W-OUT_FIELDS_W){1'b0}}, stg_r[ST_OUT].mesh,
                       stg_r[ST_OUT].hop, stg_r[ST_OUT].oy, stg_r[ST_OUT].ox};

`include "torus_route_with_mesh_select_core_macros.svh"

  `TRMS_ASSERT_NOW(a_one_dim_y_idle, out_tvalid && !dims_r[1], (stg_r[ST_OUT].oy == '0) && !stg_r[ST_OUT].mesh[1], "1D route has Y offset or Y mesh bit")
  `TRMS_ASSERT_NOW(a_hop_floor, out_tvalid, int'(stg_r[ST_OUT].hop) >= HOP_MIN, "hop count below injection plus ejection")
  `TRMS_ASSERT_NOW(a_offset_x_range, out_tvalid, (int'(stg_r[ST_OUT].ox) >= -OFF_LIM) && (int'(stg_r[ST_OUT].ox) <= OFF_LIM), "X offset not minimal")
  `TRMS_ASSERT_NEXT(a_pipe_advance, vld_r[0] && adv, vld_r[1], "word lost between first stages")

endmodule

/* tb/sv/tb_torus_route_with_mesh_select_core.sv */
// ----------------------------------------------------------------------------
// Torus route core testbench
// Drives route requests into the core under random input gaps and output
// stalls, across several register settings, and checks every returned word
// against a behavioral prediction of the minimal torus route, the hop count
// and the mesh selector.
// ----------------------------------------------------------------------------
module tb_torus_route_with_mesh_select_core;
  import trms_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 12;
  localparam int SHOW_LIMIT  = 10;

  typedef struct packed {
    coord_t                  dy;
    coord_t                  dx;
    coord_t                  sy;
    coord_t                  sx;
    logic [NODE_ID_BITS-1:0] node;
  } route_req_t;

  typedef struct packed {
    logic [MESH_W-1:0] mesh;
    logic [HOP_W-1:0]  hops;
    off_t              oy;
    off_t              ox;
  } route_word_t;

  class route_scoreboard;
    logic [DIM_W-1:0]  dims;
    rem_t              ring_x;
    rem_t              ring_y;
    rem_t              nodes;
    logic [LINK_W-1:0] links;
    route_word_t       expected_routes[$];
    int                fail_count;
    int                shown;

    function new();
      dims       = RST_DIMENSIONS;
      ring_x     = RST_RING_X;
      ring_y     = RST_RING_Y;
      nodes      = RST_NODES;
      links      = RST_LINKS;
      fail_count = 0;
      shown      = 0;
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_DIMENSIONS: dims   = val[DIM_W-1:0];
        REG_RING_X:     ring_x = val[RING_W-1:0];
        REG_RING_Y:     ring_y = val[RING_W-1:0];
        REG_NODES:      nodes  = val[RING_W-1:0];
        REG_LINKS:      links  = val[LINK_W-1:0];
        default: ;
      endcase
    endfunction

    function int ring_span(rem_t r);
      if (r == 0) return 1;
      if (int'(r) > MAX_RING) return MAX_RING;
      return int'(r);
    endfunction

    // Shortest signed hop count around one ring, with the mesh bit of that ring.
    function int ring_hop(int s, int d, int n, bit tie, output bit mesh_bit);
      int off;
      int stop;
      off = (d - s) % n;
      if (off < 0) off += n;
      if (off > n / 2) off = -(n - off);
      if (2 * off == n && tie) off = -(n - off);
      stop = s + off;
      if (stop >= n || stop < 0) begin
        mesh_bit = 1'b1;
      end else if ((2 * s) / n == (2 * d) / n) begin
        mesh_bit = tie;
      end else begin
        mesh_bit = 1'b0;
      end
      return off;
    endfunction

    function route_word_t predict_route(route_req_t q);
      int          nps;
      int          lpd;
      int          link;
      int          ox;
      int          oy;
      int          hops;
      bit          mx;
      bit          my;
      route_word_t w;
      nps  = (nodes == 0) ? 1 : int'(nodes);
      lpd  = (links == 0) ? 1 : int'(links);
      link = (int'(q.node) % nps) % lpd;
      mx   = 1'b0;
      my   = 1'b0;
      oy   = 0;
      ox   = ring_hop(q.sx, q.dx, ring_span(ring_x), link[0], mx);
      if (dims >= 2) oy = ring_hop(q.sy, q.dy, ring_span(ring_y), link[1], my);
      hops = 2 + ((ox < 0) ? -ox : ox) + ((oy < 0) ? -oy : oy);
      if (hops > HOP_MAX) hops = HOP_MAX;
      w.ox   = OFF_W'(ox);
      w.oy   = OFF_W'(oy);
      w.hops = HOP_W'(hops);
      w.mesh = {my, mx};
      return w;
    endfunction

    function void note_request(route_req_t q);
      expected_routes.push_back(predict_route(q));
    endfunction

    function void check_route(route_word_t got);
      route_word_t want;
      if (expected_routes.size() == 0) begin
        fail_count++;
        if (shown < SHOW_LIMIT) begin
          shown++;
          $display("Unexpected word: ox=%0d oy=%0d hops=%0d mesh=%0d",
                   $signed(got.ox), $signed(got.oy), got.hops, got.mesh);
        end
        return;
      end
      want = expected_routes.pop_front();
      if (want !== got) begin
        fail_count++;
        if (shown < SHOW_LIMIT) begin
          shown++;
          $display("Mismatch: expected ox=%0d oy=%0d hops=%0d mesh=%0d, got ox=%0d oy=%0d hops=%0d mesh=%0d",
                   $signed(want.ox), $signed(want.oy), want.hops, want.mesh,
                   $signed(got.ox), $signed(got.oy), got.hops, got.mesh);
        end
      end
    endfunction

    function int pending();
      return expected_routes.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  route_scoreboard sb;
  int              send_max;
  int              recv_max;
  int              cycle_count;

  torus_route_with_mesh_select_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic route_req_t mk_req(int node, int sx, int sy, int dx, int dy);
    route_req_t q;
    q.node = NODE_ID_BITS'(node);
    q.sx   = COORD_W'(sx);
    q.sy   = COORD_W'(sy);
    q.dx   = COORD_W'(dx);
    q.dy   = COORD_W'(dy);
    return q;
  endfunction

  // Mostly coordinates on the ring, often exact half-ring pairs, some anywhere.
  function automatic coord_t pick_dst(coord_t s, int n, int mode);
    if (mode < 2) return COORD_W'($urandom_range(0, 63));
    if (mode < 4) return COORD_W'((int'(s) + n / 2) % n);
    return COORD_W'($urandom_range(0, n - 1));
  endfunction

  function automatic route_req_t random_req();
    route_req_t q;
    int         nx;
    int         ny;
    int         mode;
    nx   = sb.ring_span(sb.ring_x);
    ny   = sb.ring_span(sb.ring_y);
    mode = $urandom_range(0, 9);
    q.node = ($urandom_range(0, 3) == 0) ? NODE_ID_BITS'($urandom_range(0, 255))
                                         : NODE_ID_BITS'($urandom());
    if (mode < 2) begin
      q.sx = COORD_W'($urandom_range(0, 63));
      q.sy = COORD_W'($urandom_range(0, 63));
    end else begin
      q.sx = COORD_W'($urandom_range(0, nx - 1));
      q.sy = COORD_W'($urandom_range(0, ny - 1));
    end
    q.dx = pick_dst(q.sx, nx, mode);
    q.dy = pick_dst(q.sy, ny, $urandom_range(0, 9));
    return q;
  endfunction

  task automatic send_req(route_req_t q);
    int gap;
    gap = $urandom_range(0, send_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'(q);
    do @(posedge clk); while (!in_tready);
    sb.note_request(q);
    @(negedge clk);
  endtask

  task automatic drain_outputs();
    int gap;
    forever begin
      gap = $urandom_range(0, recv_max);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_route(route_word_t'(out_tdata[OUT_FIELDS_W-1:0]));
      @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, int val);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    sb.set_reg(idx, CFG_DATA_W'(val));
    @(negedge clk);
  endtask

  task automatic apply_config(int dims, int rx, int ry, int nodes, int links);
    write_reg(REG_DIMENSIONS, dims);
    write_reg(REG_RING_X, rx);
    write_reg(REG_RING_Y, ry);
    write_reg(REG_NODES, nodes);
    write_reg(REG_LINKS, links);
    cfg_wr_en <= 1'b0;
  endtask

  int setups[7][5] = '{
    '{2, 8, 8, 4, 4},
    '{1, 64, 64, 64, 16},
    '{2, 1, 1, 1, 1},
    '{0, 0, 0, 0, 0},
    '{3, 127, 100, 127, 31},
    '{2, 7, 5, 6, 3},
    '{2, 64, 64, 64, 16}
  };

  initial begin
    sb          = new();
    cycle_count = 0;
    send_max    = 12;
    recv_max    = 12;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_addr    = '0;
    cfg_wdata   = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    fork
      drain_outputs();
    join_none

    // Reset setting: 2D, rings of 8, four nodes and four links per switch.
    send_req(mk_req(0, 0, 0, 0, 0));
    send_req(mk_req(20'hFFFFF, 63, 63, 63, 63));
    send_req(mk_req(0, 0, 0, 4, 4));
    send_req(mk_req(3, 0, 0, 4, 4));
    send_req(mk_req(1, 2, 6, 6, 2));
    send_req(mk_req(2, 7, 7, 0, 0));
    send_req(mk_req(0, 0, 0, 7, 7));
    send_req(mk_req(1, 1, 1, 2, 2));
    send_req(mk_req(0, 1, 1, 5, 6));
    send_req(mk_req(20'hAAAAA, 63, 0, 0, 63));
    send_req(mk_req(20'h55555, 40, 10, 9, 33));
    send_req(mk_req(2, 3, 4, 3, 4));
    wait_idle();
    apply_config(1, 8, 8, 4, 4);
    send_req(mk_req(3, 0, 5, 4, 1));
    send_req(mk_req(1, 7, 7, 0, 63));
    wait_idle();
    apply_config(2, 64, 64, 64, 16);
    send_req(mk_req(0, 0, 0, 32, 32));
    send_req(mk_req(3, 0, 0, 32, 32));
    send_req(mk_req(0, 63, 63, 0, 0));
    send_req(mk_req(1, 31, 32, 63, 0));
    send_req(mk_req(20'hFFFFF, 0, 63, 63, 0));

    for (int ph = 0; ph < 10; ph++) begin
      wait_idle();
      if (ph < 7) begin
        apply_config(setups[ph][0], setups[ph][1], setups[ph][2], setups[ph][3],
                     setups[ph][4]);
      end else begin
        apply_config($urandom_range(0, 3), $urandom_range(0, 127), $urandom_range(1, 64),
                     $urandom_range(0, 127), $urandom_range(0, 31));
      end
      case (ph % 4)
        0: begin send_max = 12; recv_max = 12; end
        1: begin send_max = 0;  recv_max = 0;  end
        2: begin send_max = 12; recv_max = 0;  end
        default: begin send_max = 0; recv_max = 12; end
      endcase
      for (int i = 0; i < 50; i++) begin
        if (i == 25 && ph % 3 == 0) wait_idle();
        send_req(random_req());
      end
    end

    wait_idle();
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/trms_pkg.sv
rtl/core/torus_route_with_mesh_select_core.sv
tb/sv/tb_torus_route_with_mesh_select_core.sv
